// ===== hw/rtl/fct_pkg.sv =====
// fct_pkg: shared types and constants for the frustum cull test
// plane register layout, per-request control bundle, register indexes
// no dependencies
`default_nettype none

package fct_pkg;

    localparam int CoefWidth  = 14;
    localparam int DWidth     = 22;
    localparam int FracShift  = 12;
    localparam int PlaneRegs  = 6;
    localparam int RegIdxBits = 3;

    localparam logic [RegIdxBits-1:0] REG_SHAPE_MODE = 3'd0;
    localparam logic [RegIdxBits-1:0] REG_PLANE_0    = 3'd1;
    localparam logic [RegIdxBits-1:0] REG_PLANE_1    = 3'd2;
    localparam logic [RegIdxBits-1:0] REG_PLANE_2    = 3'd3;
    localparam logic [RegIdxBits-1:0] REG_PLANE_3    = 3'd4;
    localparam logic [RegIdxBits-1:0] REG_PLANE_4    = 3'd5;
    localparam logic [RegIdxBits-1:0] REG_PLANE_5    = 3'd6;

    localparam logic SHAPE_SPHERE = 1'b0;
    localparam logic SHAPE_BOX    = 1'b1;

    // bits 63:42 d, 41:28 c, 27:14 b, 13:0 a
    typedef struct packed {
        logic signed [DWidth-1:0]    d;
        logic signed [CoefWidth-1:0] c;
        logic signed [CoefWidth-1:0] b;
        logic signed [CoefWidth-1:0] a;
    } plane_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic visible;
    } ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fct_cell.sv =====
// fct_cell: one plane test of the culling chain, two register stages
// stage a forms the three coefficient products, stage b sums and compares
// depends on fct_pkg
`default_nettype none

module fct_cell #(
    parameter int CoordWidth = 24
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              adv,
    input  wire                              mode,
    input  wire  fct_pkg::plane_t            plane,
    input  wire  fct_pkg::ctl_t              ctl_in,
    input  wire  [2:0][CoordWidth-1:0]       ctr_in,
    input  wire  [CoordWidth-2:0]            rad_in,
    input  wire  [2:0][CoordWidth-1:0]       lo_in,
    input  wire  [2:0][CoordWidth-1:0]       hi_in,
    output fct_pkg::ctl_t                    ctl_out,
    output logic [2:0][CoordWidth-1:0]       ctr_out,
    output logic [CoordWidth-2:0]            rad_out,
    output logic [2:0][CoordWidth-1:0]       lo_out,
    output logic [2:0][CoordWidth-1:0]       hi_out
);

    import fct_pkg::*;

    localparam int ProdWidth = CoefWidth + CoordWidth;
    localparam int DScaled   = DWidth + FracShift;
    localparam int SumWidth  = ((ProdWidth > DScaled) ? ProdWidth : DScaled) + 3;

    logic signed [CoefWidth-1:0]  coef [3];
    logic signed [CoordWidth-1:0] sel  [3];
    logic signed [ProdWidth-1:0]  prod [3];

    logic signed [ProdWidth-1:0]  prod_reg [3];
    ctl_t                         ctl_a_reg;
    logic [2:0][CoordWidth-1:0]   ctr_a_reg;
    logic [CoordWidth-2:0]        rad_a_reg;
    logic [2:0][CoordWidth-1:0]   lo_a_reg;
    logic [2:0][CoordWidth-1:0]   hi_a_reg;

    ctl_t                         ctl_b_reg;
    ctl_t                         ctl_b_next;
    logic [2:0][CoordWidth-1:0]   ctr_b_reg;
    logic [CoordWidth-2:0]        rad_b_reg;
    logic [2:0][CoordWidth-1:0]   lo_b_reg;
    logic [2:0][CoordWidth-1:0]   hi_b_reg;

    logic signed [SumWidth-1:0]   d_term;
    logic signed [SumWidth-1:0]   r_term;
    logic signed [SumWidth-1:0]   sum;
    logic                         reject;

    // stage a: pick the coordinate per axis, then one product per axis
    always_comb
    begin
        coef[0] = plane.a;
        coef[1] = plane.b;
        coef[2] = plane.c;
        for (int k = 0; k < 3; k++)
        begin
            if (mode == SHAPE_SPHERE)
            begin
                sel[k] = $signed(ctr_in[k]);
            end
            else if (!coef[k][CoefWidth-1])
            begin
                // farthest corner along a non-negative coefficient: larger bound
                sel[k] = ($signed(lo_in[k]) > $signed(hi_in[k])) ?
                         $signed(lo_in[k]) : $signed(hi_in[k]);
            end
            else
            begin
                sel[k] = ($signed(lo_in[k]) < $signed(hi_in[k])) ?
                         $signed(lo_in[k]) : $signed(hi_in[k]);
            end
            prod[k] = ProdWidth'(coef[k]) * ProdWidth'(sel[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
        end
        else if (adv)
        begin
            ctl_a_reg <= ctl_in;
            ctl_b_reg <= ctl_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_reg[k] <= prod[k];
            end
            ctr_a_reg <= ctr_in;
            rad_a_reg <= rad_in;
            lo_a_reg  <= lo_in;
            hi_a_reg  <= hi_in;
            ctr_b_reg <= ctr_a_reg;
            rad_b_reg <= rad_a_reg;
            lo_b_reg  <= lo_a_reg;
            hi_b_reg  <= hi_a_reg;
        end
    end

    // stage b: plane value plus d, and plus radius in sphere mode
    always_comb
    begin
        d_term = SumWidth'(plane.d) <<< FracShift;
        r_term = '0;
        if (mode == SHAPE_SPHERE)
        begin
            r_term = $signed(SumWidth'({1'b0, rad_a_reg})) <<< FracShift;
        end
        sum = SumWidth'(prod_reg[0]) + SumWidth'(prod_reg[1]) + SumWidth'(prod_reg[2])
            + d_term + r_term;
        if (mode == SHAPE_BOX)
        begin
            reject = sum[SumWidth-1];
        end
        else
        begin
            reject = sum[SumWidth-1] || (sum == '0);
        end
        ctl_b_next         = ctl_a_reg;
        ctl_b_next.visible = ctl_a_reg.visible && !reject;
    end

    assign ctl_out = ctl_b_reg;
    assign ctr_out = ctr_b_reg;
    assign rad_out = rad_b_reg;
    assign lo_out  = lo_b_reg;
    assign hi_out  = hi_b_reg;

    // a request already rejected upstream never turns visible again
    a_vis_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        adv && ctl_a_reg.valid && !ctl_a_reg.visible |=> !ctl_b_reg.visible)
        else $error("fct_cell: rejected request became visible");

    // a request in stage a reaches stage b when the chain moves
    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        adv && ctl_a_reg.valid |=> ctl_b_reg.valid)
        else $error("fct_cell: request lost between stages");

    // a held chain keeps both stages' control
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(ctl_a_reg) && $stable(ctl_b_reg))
        else $error("fct_cell: control changed while chain held");

endmodule

`default_nettype wire

// ===== hw/rtl/frustum_cull_test.sv =====
// frustum_cull_test: view-frustum culling of spheres and boxes, top level
// holds the configuration registers and a chain of fct_cell plane tests
// depends on fct_pkg and fct_cell
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------
//  vol      | vol_valid / vol_stall  | center_x/y/z, radius, box_min/max_x/y/z,
//           |                        | last_in
//  res      | res_valid / res_stall  | visible, last_out
//  apb      | psel, penable, pready  | paddr, pwrite, pwdata, prdata (64 bit)
//
// one request per cycle while the chain is not frozen; two register stages per
// plane cell (products, then sum and compare)
// the last cell's stage b is the result register; when it holds a request and
// res_stall is high the whole chain freezes and vol_stall rises
// bubbles move on whenever the result register is empty or being taken
// reset clears all valid flags, shape_mode and the six plane registers
`default_nettype none

module frustum_cull_test #(
    parameter int NUM_PLANES  = 6,
    parameter int COORD_WIDTH = 24
) (
    input  wire                          clk,
    input  wire                          rst_n,
    // apb configuration port
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [5:0]                   paddr,
    input  wire  [63:0]                  pwdata,
    output logic [63:0]                  prdata,
    output logic                         pready,
    // volume requests
    input  wire                          vol_valid,
    output logic                         vol_stall,
    input  wire  signed [COORD_WIDTH-1:0] center_x,
    input  wire  signed [COORD_WIDTH-1:0] center_y,
    input  wire  signed [COORD_WIDTH-1:0] center_z,
    input  wire  [COORD_WIDTH-2:0]       radius,
    input  wire  signed [COORD_WIDTH-1:0] box_min_x,
    input  wire  signed [COORD_WIDTH-1:0] box_min_y,
    input  wire  signed [COORD_WIDTH-1:0] box_min_z,
    input  wire  signed [COORD_WIDTH-1:0] box_max_x,
    input  wire  signed [COORD_WIDTH-1:0] box_max_y,
    input  wire  signed [COORD_WIDTH-1:0] box_max_z,
    input  wire                          last_in,
    // results
    output logic                         res_valid,
    input  wire                          res_stall,
    output logic                         visible,
    output logic                         last_out
);

    import fct_pkg::*;

    // configuration registers
    logic                          mode_reg;
    plane_t [PlaneRegs-1:0]        plane_reg;
    logic [RegIdxBits-1:0]         cfg_idx;
    logic                          cfg_wr;

    // chain links: entry p feeds cell p, entry p+1 comes out of it
    ctl_t                          ctl_chain [NUM_PLANES+1];
    logic [2:0][COORD_WIDTH-1:0]   ctr_chain [NUM_PLANES+1];
    logic [COORD_WIDTH-2:0]        rad_chain [NUM_PLANES+1];
    logic [2:0][COORD_WIDTH-1:0]   lo_chain  [NUM_PLANES+1];
    logic [2:0][COORD_WIDTH-1:0]   hi_chain  [NUM_PLANES+1];

    logic                          adv;

    // ---------------------------------------------------------------- apb
    // registers sit at 8-byte strides; low address bits are ignored
    assign cfg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= SHAPE_SPHERE;
            plane_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_SHAPE_MODE:
                begin
                    mode_reg <= pwdata[0];
                end
                REG_PLANE_0, REG_PLANE_1, REG_PLANE_2,
                REG_PLANE_3, REG_PLANE_4, REG_PLANE_5:
                begin
                    plane_reg[cfg_idx - REG_PLANE_0] <= plane_t'(pwdata);
                end
                default:
                begin
                    // writes past the last register are dropped
                end
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_SHAPE_MODE:
            begin
                prdata = {63'd0, mode_reg};
            end
            REG_PLANE_0, REG_PLANE_1, REG_PLANE_2,
            REG_PLANE_3, REG_PLANE_4, REG_PLANE_5:
            begin
                prdata = 64'(plane_reg[cfg_idx - REG_PLANE_0]);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    // ---------------------------------------------------------------- chain
    // the chain moves unless a finished result is waiting on a stalled sink
    assign adv       = !(ctl_chain[NUM_PLANES].valid && res_stall);
    assign vol_stall = !adv;

    // every request enters as visible; each cell may clear the flag
    assign ctl_chain[0] = '{valid: vol_valid, last: last_in, visible: 1'b1};
    assign ctr_chain[0] = {center_z, center_y, center_x};
    assign rad_chain[0] = radius;
    assign lo_chain[0]  = {box_min_z, box_min_y, box_min_x};
    assign hi_chain[0]  = {box_max_z, box_max_y, box_max_x};

    for (genvar p = 0; p < NUM_PLANES; p++)
    begin : g_cell
        fct_cell #(
            .CoordWidth (COORD_WIDTH)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .mode    (mode_reg),
            .plane   (plane_reg[p]),
            .ctl_in  (ctl_chain[p]),
            .ctr_in  (ctr_chain[p]),
            .rad_in  (rad_chain[p]),
            .lo_in   (lo_chain[p]),
            .hi_in   (hi_chain[p]),
            .ctl_out (ctl_chain[p+1]),
            .ctr_out (ctr_chain[p+1]),
            .rad_out (rad_chain[p+1]),
            .lo_out  (lo_chain[p+1]),
            .hi_out  (hi_chain[p+1])
        );
    end

    // last cell's stage b is the result register
    assign res_valid = ctl_chain[NUM_PLANES].valid;
    assign visible   = ctl_chain[NUM_PLANES].visible;
    assign last_out  = ctl_chain[NUM_PLANES].last;

    // a waiting, stalled result freezes the first cell's output as well
    a_chain_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(ctl_chain[1]))
        else $error("frustum_cull_test: chain moved while result stalled");

    // configuration changes only through an apb write
    a_cfg_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_wr |=> $stable(mode_reg) && $stable(plane_reg))
        else $error("frustum_cull_test: configuration changed without a write");

    // the shape mode register reads back as a single bit
    a_mode_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && !pwrite && (cfg_idx == REG_SHAPE_MODE) |-> prdata[63:1] == '0)
        else $error("frustum_cull_test: shape mode readback has stray bits");

endmodule

`default_nettype wire
